// ===== hw/rtl/complex_vector_alu_macros.svh =====
// Assertion macros for the complex vector ALU.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef COMPLEX_VECTOR_ALU_MACROS_SVH
`define COMPLEX_VECTOR_ALU_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, masked while reset is high.
`define CVA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("complex_vector_alu assertion failed");
// Checked property that also holds across reset.
`define CVA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("complex_vector_alu assertion failed");
`else
`define CVA_ASSERT(label, clk, rst, prop)
`define CVA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/cva_pkg.sv =====
// Shared types and constants for the complex vector ALU.
// No dependencies; the other RTL files that use it refer to it by scoped names.
package cva_pkg;

  localparam int unsigned Q_FRAC = 14;
  localparam int unsigned CFG_INDEX_W = 8;

  typedef enum logic [2:0] {
    OP_CONJ  = 3'd0,
    OP_NEG   = 3'd1,
    OP_SCALE = 3'd2,
    OP_SHIFT = 3'd3,
    OP_ADD   = 3'd4,
    OP_SUB   = 3'd5,
    OP_MUL   = 3'd6,
    OP_AXPBY = 3'd7
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ALPHA_RE = 8'd0,
    CFG_ALPHA_IM = 8'd1,
    CFG_BETA_RE  = 8'd2,
    CFG_BETA_IM  = 8'd3
  } cfg_reg_t;

  localparam logic signed [15:0] ALPHA_RE_RESET = 16'sd16384;
  localparam logic signed [15:0] COEF_ZERO      = 16'sd0;
  localparam logic signed [33:0] ROUND_HALF     = 34'sd8192;
  localparam logic signed [19:0] SAT_MAX_W      = 20'sd32767;
  localparam logic signed [19:0] SAT_MIN_W      = -20'sd32768;
  localparam logic signed [15:0] SAT_MAX        = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN        = 16'sh8000;

  typedef struct packed {
    op_t               operation;
    logic signed [15:0] x_re;
    logic signed [15:0] x_im;
    logic signed [15:0] y_re;
    logic signed [15:0] y_im;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } coef_t;

  // Partial products of one element and the result of the operations
  // that need no multiplier.
  typedef struct packed {
    op_t                operation;
    logic               last;
    logic signed [31:0] rr;
    logic signed [31:0] ii;
    logic signed [31:0] ri;
    logic signed [31:0] ir;
    logic signed [31:0] brr;
    logic signed [31:0] bii;
    logic signed [31:0] bri;
    logic signed [31:0] bir;
    logic signed [16:0] lin_re;
    logic signed [16:0] lin_im;
  } prod_t;

  typedef struct packed {
    logic signed [15:0] z_re;
    logic signed [15:0] z_im;
    logic               saturated;
    logic               last_out;
  } result_t;

endpackage

// ===== hw/rtl/cva_operand_if.sv =====
// Input channel of the complex vector ALU: one element pair per transaction.
// Depends on nothing else.
interface cva_operand_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] x_re;
  logic signed [15:0] x_im;
  logic signed [15:0] y_re;
  logic signed [15:0] y_im;
  logic               last;

  modport source (output valid, operation, x_re, x_im, y_re, y_im, last, input ready);
  modport sink (input valid, operation, x_re, x_im, y_re, y_im, last, output ready);
endinterface

// ===== hw/rtl/cva_result_if.sv =====
// Output channel of the complex vector ALU: one result element per transaction.
// Depends on nothing else.
interface cva_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] z_re;
  logic signed [15:0] z_im;
  logic               saturated;
  logic               last_out;

  modport source (output valid, z_re, z_im, saturated, last_out, input ready);
  modport sink (input valid, z_re, z_im, saturated, last_out, output ready);
endinterface

// ===== hw/rtl/cva_cfg_if.sv =====
// Configuration write channel of the complex vector ALU.
// Uses the index width from cva_pkg.
interface cva_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cva_pkg::CFG_INDEX_W-1:0]    index;
  logic signed [15:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cva_mult.sv =====
// Product stage: eight 16x16 signed multipliers and the linear operations,
// captured in one pipeline register. Uses cva_pkg types.
module cva_mult (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cva_pkg::item_t  item,
  input  cva_pkg::coef_t  coef,
  output logic            out_valid,
  input  logic            out_ready,
  output cva_pkg::prod_t  prod
);

  logic               valid;
  cva_pkg::prod_t     prod_next;
  cva_pkg::prod_t     prod_q;

  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;
  logic signed [16:0] xr_w;
  logic signed [16:0] xi_w;
  logic signed [16:0] yr_w;
  logic signed [16:0] yi_w;
  logic signed [16:0] ar_w;
  logic signed [16:0] ai_w;

  // The complex multiply uses x times y; scale and axpby use alpha times x.
  always_comb begin
    if (item.operation == cva_pkg::OP_MUL) begin
      a_re = item.x_re;
      a_im = item.x_im;
      b_re = item.y_re;
      b_im = item.y_im;
    end else begin
      a_re = coef.a_re;
      a_im = coef.a_im;
      b_re = item.x_re;
      b_im = item.x_im;
    end
  end

  assign xr_w = 17'(item.x_re);
  assign xi_w = 17'(item.x_im);
  assign yr_w = 17'(item.y_re);
  assign yi_w = 17'(item.y_im);
  assign ar_w = 17'(coef.a_re);
  assign ai_w = 17'(coef.a_im);

  always_comb begin
    prod_next.operation = item.operation;
    prod_next.last      = item.last;
    prod_next.rr        = 32'(a_re) * 32'(b_re);
    prod_next.ii        = 32'(a_im) * 32'(b_im);
    prod_next.ri        = 32'(a_re) * 32'(b_im);
    prod_next.ir        = 32'(a_im) * 32'(b_re);
    prod_next.brr       = 32'(coef.b_re) * 32'(item.y_re);
    prod_next.bii       = 32'(coef.b_im) * 32'(item.y_im);
    prod_next.bri       = 32'(coef.b_re) * 32'(item.y_im);
    prod_next.bir       = 32'(coef.b_im) * 32'(item.y_re);
    case (item.operation)
      cva_pkg::OP_CONJ: begin
        prod_next.lin_re = xr_w;
        prod_next.lin_im = -xi_w;
      end
      cva_pkg::OP_NEG: begin
        prod_next.lin_re = -xr_w;
        prod_next.lin_im = -xi_w;
      end
      cva_pkg::OP_SHIFT: begin
        prod_next.lin_re = ar_w + xr_w;
        prod_next.lin_im = ai_w + xi_w;
      end
      cva_pkg::OP_ADD: begin
        prod_next.lin_re = xr_w + yr_w;
        prod_next.lin_im = xi_w + yi_w;
      end
      cva_pkg::OP_SUB: begin
        prod_next.lin_re = xr_w - yr_w;
        prod_next.lin_im = xi_w - yi_w;
      end
      default: begin
        prod_next.lin_re = xr_w;
        prod_next.lin_im = xi_w;
      end
    endcase
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_q <= prod_next;
    end
  end

  assign out_valid = valid;
  assign prod      = prod_q;

endmodule

// ===== hw/rtl/cva_combine.sv =====
// Result stage: sums the partial products, rounds half up, saturates each
// part and registers the result. Uses cva_pkg types and constants.
module cva_combine (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cva_pkg::prod_t   prod,
  output logic             out_valid,
  input  logic             out_ready,
  output cva_pkg::result_t result
);

  logic               valid;
  cva_pkg::result_t   result_next;
  cva_pkg::result_t   result_q;

  logic signed [33:0] acc_re;
  logic signed [33:0] acc_im;
  logic signed [33:0] rnd_re;
  logic signed [33:0] rnd_im;
  logic signed [19:0] wide_re;
  logic signed [19:0] wide_im;
  logic               uses_mult;
  logic               clip_re;
  logic               clip_im;

  always_comb begin
    acc_re = 34'(prod.rr) - 34'(prod.ii);
    acc_im = 34'(prod.ri) + 34'(prod.ir);
    if (prod.operation == cva_pkg::OP_AXPBY) begin
      acc_re = acc_re + 34'(prod.brr) - 34'(prod.bii);
      acc_im = acc_im + 34'(prod.bri) + 34'(prod.bir);
    end
    // Adding one half and dropping the fraction bits rounds exact halves up.
    rnd_re = acc_re + cva_pkg::ROUND_HALF;
    rnd_im = acc_im + cva_pkg::ROUND_HALF;

    uses_mult = (prod.operation == cva_pkg::OP_SCALE) ||
                (prod.operation == cva_pkg::OP_MUL) ||
                (prod.operation == cva_pkg::OP_AXPBY);
    if (uses_mult) begin
      wide_re = signed'(rnd_re[33:cva_pkg::Q_FRAC]);
      wide_im = signed'(rnd_im[33:cva_pkg::Q_FRAC]);
    end else begin
      wide_re = 20'(prod.lin_re);
      wide_im = 20'(prod.lin_im);
    end

    clip_re = 1'b1;
    clip_im = 1'b1;
    if (wide_re > cva_pkg::SAT_MAX_W) begin
      result_next.z_re = cva_pkg::SAT_MAX;
    end else if (wide_re < cva_pkg::SAT_MIN_W) begin
      result_next.z_re = cva_pkg::SAT_MIN;
    end else begin
      result_next.z_re = wide_re[15:0];
      clip_re = 1'b0;
    end
    if (wide_im > cva_pkg::SAT_MAX_W) begin
      result_next.z_im = cva_pkg::SAT_MAX;
    end else if (wide_im < cva_pkg::SAT_MIN_W) begin
      result_next.z_im = cva_pkg::SAT_MIN;
    end else begin
      result_next.z_im = wide_im[15:0];
      clip_im = 1'b0;
    end
    result_next.saturated = clip_re || clip_im;
    result_next.last_out  = prod.last;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result_q <= result_next;
    end
  end

  assign out_valid = valid;
  assign result    = result_q;

endmodule

// ===== hw/rtl/complex_vector_alu.sv =====
// Complex Q2.14 vector ALU, one element per transaction.
// Pipeline: the input register loads at the accepting edge, then the product and result
// registers follow. Throughput: one element per cycle while result.ready is high,
// set by the product stage of eight parallel 16x16 multipliers.
// Reset clears all pipeline valid bits and loads alpha = 1.0, beta = 0.
// Depends on cva_pkg, the channel interfaces, cva_mult and cva_combine.
`include "complex_vector_alu_macros.svh"

module complex_vector_alu (
  input  logic         clk,
  input  logic         rst,
  cva_cfg_if.sink      cfg,
  cva_operand_if.sink  operand,
  cva_result_if.source result
);

  logic signed [15:0] alpha_re;
  logic signed [15:0] alpha_im;
  logic signed [15:0] beta_re;
  logic signed [15:0] beta_im;

  logic               in_valid;
  cva_pkg::item_t     in_item;
  cva_pkg::coef_t     coef;

  logic               m_ready;
  logic               m_valid;
  cva_pkg::prod_t     m_prod;
  logic               c_ready;
  cva_pkg::result_t   c_result;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_re <= cva_pkg::ALPHA_RE_RESET;
      alpha_im <= cva_pkg::COEF_ZERO;
      beta_re  <= cva_pkg::COEF_ZERO;
      beta_im  <= cva_pkg::COEF_ZERO;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        cva_pkg::CFG_ALPHA_RE: alpha_re <= cfg.data;
        cva_pkg::CFG_ALPHA_IM: alpha_im <= cfg.data;
        cva_pkg::CFG_BETA_RE:  beta_re  <= cfg.data;
        cva_pkg::CFG_BETA_IM:  beta_im  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign coef = '{a_re: alpha_re, a_im: alpha_im, b_re: beta_re, b_im: beta_im};

  // Input register keeps the multiplier inputs off the port timing.
  assign operand.ready = !in_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (operand.ready) begin
      in_valid <= operand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operand.valid && operand.ready) begin
      in_item.operation <= cva_pkg::op_t'(operand.operation);
      in_item.x_re      <= operand.x_re;
      in_item.x_im      <= operand.x_im;
      in_item.y_re      <= operand.y_re;
      in_item.y_im      <= operand.y_im;
      in_item.last      <= operand.last;
    end
  end

  cva_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (m_ready),
    .item      (in_item),
    .coef      (coef),
    .out_valid (m_valid),
    .out_ready (c_ready),
    .prod      (m_prod)
  );

  cva_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (c_ready),
    .prod      (m_prod),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .result    (c_result)
  );

  assign result.z_re      = c_result.z_re;
  assign result.z_im      = c_result.z_im;
  assign result.saturated = c_result.saturated;
  assign result.last_out  = c_result.last_out;

  `CVA_ASSERT_ALWAYS(a_reset_coef, clk, rst |=> (alpha_re == cva_pkg::ALPHA_RE_RESET) && (beta_re == cva_pkg::COEF_ZERO))
  `CVA_ASSERT(a_cfg_alpha_re, clk, rst, cfg.valid && (cfg.index == cva_pkg::CFG_ALPHA_RE) |=> alpha_re == $past(cfg.data))
  `CVA_ASSERT(a_input_backpressure, clk, rst, in_valid && !m_ready |-> !operand.ready)
  `CVA_ASSERT(a_result_from_pipe, clk, rst, $rose(result.valid) |-> $past(m_valid))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the complex Q2.14 vector ALU: directed corner cases, then
// random element streams under several alpha/beta settings, with random stalls on both sides.
// Depends on cva_pkg, the three channel interfaces and the complex_vector_alu top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF      = 5;
  localparam int          LIMIT_CYCLES  = 600000;
  localparam int          PIPE_SETTLE   = 6;
  localparam int          MAX_WAIT      = 17;
  localparam int          STREAM_PHASES = 13;
  localparam int          PHASE_ITEMS   = 150;
  localparam longint      ROUND_BIAS    = 64'sd8192;
  localparam longint      Z_MAX         = 64'sd32767;
  localparam longint      Z_MIN         = -64'sd32768;
  localparam logic signed [15:0] Q_ONE  = 16'sd16384;
  localparam logic signed [15:0] Q_MAX  = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN  = 16'sh8000;

  typedef logic [cva_pkg::CFG_INDEX_W-1:0] index_t;

  logic clk;
  logic rst;

  cva_cfg_if     cfg_ch ();
  cva_operand_if operand_ch ();
  cva_result_if  result_ch ();

  complex_vector_alu i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .operand (operand_ch),
    .result  (result_ch)
  );

  // Local copy of the coefficient registers.
  logic signed [15:0] coef_alpha_re;
  logic signed [15:0] coef_alpha_im;
  logic signed [15:0] coef_beta_re;
  logic signed [15:0] coef_beta_im;

  cva_pkg::result_t pending_results[$];
  int               failures;
  int               cycle_count;
  bit               send_idle;
  bit               recv_idle;
  int               vector_left;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint round_q14(input longint acc);
    return (acc + ROUND_BIAS) >>> cva_pkg::Q_FRAC;
  endfunction

  function automatic logic signed [15:0] saturate16(input longint v, output bit clip);
    clip = 1'b0;
    if (v > Z_MAX) begin
      clip = 1'b1;
      return Q_MAX;
    end
    if (v < Z_MIN) begin
      clip = 1'b1;
      return Q_MIN;
    end
    return v[15:0];
  endfunction

  function automatic cva_pkg::result_t alu_predict(input cva_pkg::item_t elem);
    longint xr, xi, yr, yi, ar, ai, br, bi, zr, zi;
    bit clip_re, clip_im;
    cva_pkg::result_t res;
    xr = longint'(elem.x_re);
    xi = longint'(elem.x_im);
    yr = longint'(elem.y_re);
    yi = longint'(elem.y_im);
    ar = longint'(coef_alpha_re);
    ai = longint'(coef_alpha_im);
    br = longint'(coef_beta_re);
    bi = longint'(coef_beta_im);
    case (elem.operation)
      cva_pkg::OP_CONJ: begin
        zr = xr;
        zi = -xi;
      end
      cva_pkg::OP_NEG: begin
        zr = -xr;
        zi = -xi;
      end
      cva_pkg::OP_SCALE: begin
        zr = round_q14(ar * xr - ai * xi);
        zi = round_q14(ar * xi + ai * xr);
      end
      cva_pkg::OP_SHIFT: begin
        zr = ar + xr;
        zi = ai + xi;
      end
      cva_pkg::OP_ADD: begin
        zr = xr + yr;
        zi = xi + yi;
      end
      cva_pkg::OP_SUB: begin
        zr = xr - yr;
        zi = xi - yi;
      end
      cva_pkg::OP_MUL: begin
        zr = round_q14(xr * yr - xi * yi);
        zi = round_q14(xr * yi + xi * yr);
      end
      cva_pkg::OP_AXPBY: begin
        zr = round_q14(ar * xr - ai * xi + br * yr - bi * yi);
        zi = round_q14(ar * xi + ai * xr + br * yi + bi * yr);
      end
      default: begin
        zr = 0;
        zi = 0;
      end
    endcase
    res.z_re      = saturate16(zr, clip_re);
    res.z_im      = saturate16(zi, clip_im);
    res.saturated = clip_re | clip_im;
    res.last_out  = elem.last;
    return res;
  endfunction

  // Operands and coefficients lean toward the extremes and small values.
  function automatic logic signed [15:0] random_q14();
    logic [15:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(0, 1024))) - 16'sd512;
      default: return raw;
    endcase
  endfunction

  task automatic send_element(input cva_pkg::op_t op, input logic signed [15:0] xr,
                              input logic signed [15:0] xi, input logic signed [15:0] yr,
                              input logic signed [15:0] yi, input logic last);
    int gap;
    cva_pkg::item_t elem;
    gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
    elem.operation = op;
    elem.x_re      = xr;
    elem.x_im      = xi;
    elem.y_re      = yr;
    elem.y_im      = yi;
    elem.last      = last;
    if (gap > 0) begin
      operand_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operand_ch.valid     = 1'b1;
    operand_ch.operation = elem.operation;
    operand_ch.x_re      = elem.x_re;
    operand_ch.x_im      = elem.x_im;
    operand_ch.y_re      = elem.y_re;
    operand_ch.y_im      = elem.y_im;
    operand_ch.last      = elem.last;
    @(posedge clk);
    while (!operand_ch.ready) @(posedge clk);
    pending_results.push_back(alu_predict(elem));
    @(negedge clk);
    operand_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  // Registers change only once the pipeline is empty.
  task automatic write_register(input logic [cva_pkg::CFG_INDEX_W-1:0] idx,
                                input logic signed [15:0] value);
    wait_drained();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      cva_pkg::CFG_ALPHA_RE: coef_alpha_re = value;
      cva_pkg::CFG_ALPHA_IM: coef_alpha_im = value;
      cva_pkg::CFG_BETA_RE:  coef_beta_re  = value;
      cva_pkg::CFG_BETA_IM:  coef_beta_im  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_coefficients(input logic signed [15:0] a_re, input logic signed [15:0] a_im,
                                  input logic signed [15:0] b_re, input logic signed [15:0] b_im);
    write_register(cva_pkg::CFG_ALPHA_RE, a_re);
    write_register(cva_pkg::CFG_ALPHA_IM, a_im);
    write_register(cva_pkg::CFG_BETA_RE, b_re);
    write_register(cva_pkg::CFG_BETA_IM, b_im);
  endtask

  // Result side: random stall before each transaction, then compare with the oldest prediction.
  initial begin : result_checker
    int stall;
    cva_pkg::result_t want;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("unexpected result: z_re %0d z_im %0d", result_ch.z_re, result_ch.z_im);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.z_re !== want.z_re) begin
          $error("z_re mismatch: expected %0d, actual %0d", want.z_re, result_ch.z_re);
          failures++;
        end
        if (result_ch.z_im !== want.z_im) begin
          $error("z_im mismatch: expected %0d, actual %0d", want.z_im, result_ch.z_im);
          failures++;
        end
        if (result_ch.saturated !== want.saturated) begin
          $error("saturated mismatch: expected %0b, actual %0b", want.saturated,
                 result_ch.saturated);
          failures++;
        end
        if (result_ch.last_out !== want.last_out) begin
          $error("last_out mismatch: expected %0b, actual %0b", want.last_out,
                 result_ch.last_out);
          failures++;
        end
      end
      @(negedge clk);
    end
  end

  // Alpha = 1.0 and beta = 0 straight out of reset.
  task automatic test_reset_values();
    send_element(cva_pkg::OP_SCALE, 16'sd12345, -16'sd2222, 16'sd0, 16'sd0, 1'b0);
    send_element(cva_pkg::OP_SHIFT, 16'sd20000, 16'sd100, 16'sd0, 16'sd0, 1'b0);
    send_element(cva_pkg::OP_AXPBY, -16'sd7000, 16'sd3000, Q_MAX, Q_MIN, 1'b1);
  endtask

  task automatic test_special_cases();
    // Negating the most negative value clips.
    send_element(cva_pkg::OP_CONJ, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 1'b0);
    send_element(cva_pkg::OP_NEG, Q_MIN, Q_MIN, 16'sd0, 16'sd0, 1'b0);
    send_element(cva_pkg::OP_NEG, Q_MAX, 16'sd1, 16'sh5a5a, -16'sd1, 1'b1);
    send_element(cva_pkg::OP_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0);
    send_element(cva_pkg::OP_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b1);
    send_element(cva_pkg::OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    send_element(cva_pkg::OP_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1);
  endtask

  // With alpha equal to one LSB each product is an exact half or a remainder.
  task automatic test_rounding();
    set_coefficients(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_element(cva_pkg::OP_SCALE, 16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 1'b0);
    send_element(cva_pkg::OP_SCALE, -16'sd24576, 16'sd24576, 16'sd0, 16'sd0, 1'b0);
    send_element(cva_pkg::OP_SCALE, 16'sd8191, -16'sd8193, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_coefficient_extremes();
    set_coefficients(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_element(cva_pkg::OP_AXPBY, Q_MIN, Q_MAX, Q_MIN, Q_MIN, 1'b0);
    send_element(cva_pkg::OP_SHIFT, Q_MIN, Q_MAX, 16'sd0, 16'sd0, 1'b1);
    set_coefficients(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_element(cva_pkg::OP_AXPBY, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 1'b0);
    send_element(cva_pkg::OP_SCALE, Q_MAX, Q_MAX, 16'sd0, 16'sd0, 1'b1);
    set_coefficients(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_element(cva_pkg::OP_AXPBY, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b1);
  endtask

  // Writes to an index past the last register leave the coefficients alone.
  task automatic test_ignored_index();
    logic [cva_pkg::CFG_INDEX_W-1:0] bad_index;
    set_coefficients(Q_ONE, 16'sd0, Q_ONE, 16'sd0);
    bad_index = index_t'($urandom_range(4, 255));
    write_register(bad_index, Q_MIN);
    write_register(8'hff, Q_MAX);
    send_element(cva_pkg::OP_AXPBY, 16'sd1000, -16'sd1000, 16'sd2000, 16'sd3000, 1'b1);
    send_element(cva_pkg::OP_SHIFT, 16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_random_stream();
    logic [2:0] code;
    logic [cva_pkg::CFG_INDEX_W-1:0] bad_index;
    bit last;
    for (int phase = 0; phase < STREAM_PHASES; phase++) begin
      case (phase)
        0: set_coefficients(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        1: set_coefficients(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        2: set_coefficients(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        3: set_coefficients(Q_ONE, 16'sd0, Q_ONE, 16'sd0);
        default: set_coefficients(random_q14(), random_q14(), random_q14(), random_q14());
      endcase
      if ($urandom_range(0, 2) == 0) begin
        bad_index = index_t'($urandom_range(4, 255));
        write_register(bad_index, random_q14());
      end
      send_idle = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_idle = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-stream pause so the whole pipeline empties once every four phases.
        if (n == PHASE_ITEMS / 2 && phase % 4 == 1) wait_drained();
        if (vector_left == 0) vector_left = $urandom_range(1, 16);
        last = (vector_left == 1);
        vector_left--;
        if ($urandom_range(0, 19) == 0) last = 1'($urandom_range(0, 1));
        code = 3'($urandom_range(0, 7));
        send_element(cva_pkg::op_t'(code), random_q14(), random_q14(), random_q14(),
                     random_q14(), last);
      end
    end
  endtask

  initial begin : stimulus
    rst                  = 1'b1;
    failures             = 0;
    cycle_count          = 0;
    send_idle            = 1'b0;
    recv_idle            = 1'b0;
    vector_left          = 0;
    coef_alpha_re        = cva_pkg::ALPHA_RE_RESET;
    coef_alpha_im        = cva_pkg::COEF_ZERO;
    coef_beta_re         = cva_pkg::COEF_ZERO;
    coef_beta_im         = cva_pkg::COEF_ZERO;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    operand_ch.valid     = 1'b0;
    operand_ch.operation = '0;
    operand_ch.x_re      = '0;
    operand_ch.x_im      = '0;
    operand_ch.y_re      = '0;
    operand_ch.y_im      = '0;
    operand_ch.last      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_special_cases();
    test_rounding();
    test_coefficient_extremes();
    test_ignored_index();
    test_random_stream();

    wait_drained();
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
